// ===== rtl/ssbj_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssbj_pkg
// Shared types and constants for the sorted-set band join unit.
// ----------------------------------------------------------------------------
package ssbj_pkg;

    localparam int MAX_SET     = 4096;
    localparam int VALUE_WIDTH = 64;
    localparam int WORD_W      = 64;
    localparam int ADDR_W      = $clog2(MAX_SET);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int IDX_W       = 12;
    localparam int HITS_W      = 7;
    localparam int CMP_W       = (CNT_W > HITS_W) ? CNT_W : HITS_W;
    localparam int OUT_LIMIT   = 64;
    localparam int CFG_IDX_W   = 3;

    localparam logic [WORD_W-1:0] VALUE_MASK =
        WORD_W'((65'd1 << VALUE_WIDTH) - 65'd1);

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_PAIR    = 2'd0;
    localparam logic [1:0] ST_NOMATCH = 2'd1;
    localparam logic [1:0] ST_BOTHSLOP = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOP_BELOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOP_ABOVE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIT_CAP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_ENABLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RARE_IS_SET1 = 3'd4;

    localparam logic [HITS_W-1:0] HIT_CAP_RESET = 7'd5;

    typedef struct packed {
        logic [1:0]        operation;
        logic [WORD_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] set1_index;
        logic [IDX_W-1:0] set2_index;
        logic [1:0]       status;
        logic             last;
    } t_out_word;

    typedef struct packed {
        logic clear;
        logic append;
        logic query;
        logic step;
        logic lo_done;
        logic decide;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic lo_adv;
        logic hi_adv;
        logic out_free;
        logic emit_last;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== rtl/ssbj_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssbj_ctrl
// Sequencer: window advance, window end scan, cap decision, result emission.
// ----------------------------------------------------------------------------
module ssbj_ctrl
    import ssbj_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic [1:0] i_operation,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LO   = 5'b00010,
        S_HI   = 5'b00100,
        S_DEC  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_operation)
                        OP_CLEAR:  o_cmd.clear = 1'b1;
                        OP_APPEND: o_cmd.append = 1'b1;
                        OP_QUERY: begin
                            o_cmd.query = 1'b1;
                            n_state     = S_LO;
                        end
                        default: ;
                    endcase
                end
            end
            S_LO: begin
                if (i_stat.lo_adv) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.lo_done = 1'b1;
                    n_state       = S_HI;
                end
            end
            S_HI: begin
                if (i_stat.hi_adv) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/ssbj_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ssbj_datapath
// Value store, window pointers, band compares, cap logic and output register.
// ----------------------------------------------------------------------------
module ssbj_datapath
    import ssbj_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data,
    input  wire logic [WORD_W-1:0]    i_value,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output t_out_word                 o_out_word
);

    // configuration
    logic [WORD_W-1:0] r_slop_below;
    logic [WORD_W-1:0] r_slop_above;
    logic [HITS_W-1:0] r_hit_cap;
    logic              r_cap_enable;
    logic              r_rare_is_set1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slop_below   <= '0;
            r_slop_above   <= '0;
            r_hit_cap      <= HIT_CAP_RESET;
            r_cap_enable   <= 1'b1;
            r_rare_is_set1 <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SLOP_BELOW:   r_slop_below   <= i_cfg_data;
                REG_SLOP_ABOVE:   r_slop_above   <= i_cfg_data;
                REG_HIT_CAP:      r_hit_cap      <= i_cfg_data[HITS_W-1:0];
                REG_CAP_ENABLE:   r_cap_enable   <= i_cfg_data[0];
                REG_RARE_IS_SET1: r_rare_is_set1 <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [WORD_W-1:0] w_value;
    assign w_value = i_value & VALUE_MASK;

    // store
    logic [WORD_W-1:0] r_mem [MAX_SET];
    logic [WORD_W-1:0] r_rdata;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_ws;
    logic [CNT_W-1:0]  r_ptr, n_ptr;
    logic [IDX_W-1:0]  r_qcnt;
    logic [IDX_W-1:0]  r_rare_idx;
    logic [WORD_W-1:0] r_value;
    logic [WORD_W:0]   r_hi;
    logic              w_has_room;

    assign w_has_room = (r_count < CNT_W'(MAX_SET));

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.query) begin
            n_ptr = r_ws;
        end else if (i_cmd.step) begin
            n_ptr = r_ptr + CNT_W'(1);
        end
    end

    // read address follows the next pointer, so r_rdata is mem[r_ptr]
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && w_has_room) begin
            r_mem[r_count[ADDR_W-1:0]] <= w_value;
        end
        r_rdata <= r_mem[n_ptr[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ws    <= '0;
            r_qcnt  <= '0;
            r_ptr   <= '0;
        end else begin
            r_ptr <= n_ptr;
            if (i_cmd.clear) begin
                r_count <= '0;
                r_ws    <= '0;
                r_qcnt  <= '0;
            end else begin
                if (i_cmd.append && w_has_room) begin
                    r_count <= r_count + CNT_W'(1);
                end
                if (i_cmd.query) begin
                    r_qcnt <= r_qcnt + IDX_W'(1);
                end
                if (i_cmd.lo_done) begin
                    r_ws <= r_ptr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_value    <= w_value;
            r_hi       <= {1'b0, w_value} + {1'b0, r_slop_above};
            r_rare_idx <= r_qcnt;
        end
    end

    // band compares at one bit above the word width
    logic [WORD_W:0] w_lo_sum;
    logic            w_in_store;
    assign w_lo_sum   = {1'b0, r_rdata} + {1'b0, r_slop_below};
    assign w_in_store = (r_ptr < r_count);
    assign o_stat.lo_adv = w_in_store && (w_lo_sum < {1'b0, r_value});
    assign o_stat.hi_adv = w_in_store && ({1'b0, r_rdata} <= r_hi);

    // cap decision
    logic [CNT_W-1:0]  r_j, r_b, n_a, n_b;
    logic              r_single, n_single;
    logic [1:0]        r_status, n_status;
    logic [CNT_W-1:0]  w_n;
    logic [HITS_W-1:0] w_cap;

    assign w_n = r_ptr - r_ws;

    always_comb begin
        if (r_hit_cap == '0) begin
            w_cap = HITS_W'(1);
        end else if (r_hit_cap > HITS_W'(OUT_LIMIT)) begin
            w_cap = HITS_W'(OUT_LIMIT);
        end else begin
            w_cap = r_hit_cap;
        end
    end

    always_comb begin
        n_a      = r_ws;
        n_b      = r_ptr;
        n_single = 1'b0;
        n_status = ST_PAIR;
        if (w_n == '0) begin
            n_single = 1'b1;
            n_status = ST_NOMATCH;
        end else begin
            if (r_cap_enable && (CMP_W'(w_n) > CMP_W'(w_cap))) begin
                if (r_slop_below == '0) begin
                    n_b = r_ws + CNT_W'(w_cap);
                end else if (r_slop_above == '0) begin
                    n_a = r_ptr - CNT_W'(w_cap);
                end else begin
                    n_single = 1'b1;
                    n_status = ST_BOTHSLOP;
                end
            end
            if (CMP_W'(n_b - n_a) > CMP_W'(OUT_LIMIT)) begin
                n_b = n_a + CNT_W'(OUT_LIMIT);
            end
        end
    end

    // emission
    logic             r_out_valid;
    t_out_word        r_out_word;
    logic [IDX_W-1:0] w_stor_idx;
    logic             w_last;

    assign w_last     = r_single || ((r_j + CNT_W'(1)) == r_b);
    assign w_stor_idx = r_single ? '0 : IDX_W'(r_j);

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_j      <= n_a;
            r_b      <= n_b;
            r_single <= n_single;
            r_status <= n_status;
        end else if (i_cmd.emit) begin
            r_j <= r_j + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_word.set1_index <= r_rare_is_set1 ? r_rare_idx : w_stor_idx;
            r_out_word.set2_index <= r_rare_is_set1 ? w_stor_idx : r_rare_idx;
            r_out_word.status     <= r_single ? r_status : ST_PAIR;
            r_out_word.last       <= w_last;
        end
    end

    assign o_stat.out_free  = !r_out_valid || i_out_ready;
    assign o_stat.emit_last = w_last;
    assign o_out_valid      = r_out_valid;
    assign o_out_word       = r_out_word;

endmodule
`default_nettype wire

// ===== rtl/sorted_set_band_join_unit.sv =====
`default_nettype none
// Clear, append and unused codes are accepted in idle, one word per cycle while
// no query is in progress. Query: the window start moves past the low elements,
// the matching elements are scanned, the cap decision is made, then one result
// per cycle while the output is not stalled. Scans read one store word per
// cycle from the value memory.
// Synchronous active-low reset clears counters and loads register defaults.
// ----------------------------------------------------------------------------
// sorted_set_band_join_unit
// Stores an ascending frequent list and band-joins each rare value against it.
// ----------------------------------------------------------------------------
module sorted_set_band_join_unit
    import ssbj_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [WORD_W-1:0]    i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    ssbj_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_in_word.operation),
        .o_in_ready  (o_in_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ssbj_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_in_word.value),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule
`default_nettype wire
